>>> design/swsplit_pkg.sv
package swsplit_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 10;

  // result queue depth; room for two results is needed to take a beat
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;

  localparam logic [COUNT_W-1:0] MAX_WORDS_RESET = 10'd64;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_WORD_END  = 2'd1,
    KIND_LINE_DONE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNMATCHED = 2'd1,
    ST_TOO_MANY  = 2'd2
  } status_t;

  typedef struct packed {
    logic               in_word;
    logic               in_dquote;
    logic               in_squote;
    logic               escape_pending;
    logic [COUNT_W-1:0] words_done;
    logic               overflowed;
  } split_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  byte_out;
    logic [COUNT_W-1:0] word_count;
    status_t            status;
    logic               last;
  } result_t;

endpackage

>>> design/swsplit_step.sv
// per-beat tokenizer rule: next state and up to two results
module swsplit_step (
  input  swsplit_pkg::split_state_t       st,
  input  logic [swsplit_pkg::BYTE_W-1:0]  byte_in,
  input  logic                            line_end,
  input  logic [swsplit_pkg::COUNT_W-1:0] max_words,
  output swsplit_pkg::split_state_t       st_next,
  output logic                            res0_valid,
  output swsplit_pkg::result_t            res0,
  output logic                            res1_valid,
  output swsplit_pkg::result_t            res1
);

  logic                            is_delim;
  logic                            quoted;
  logic [swsplit_pkg::COUNT_W-1:0] words_inc;
  logic                            limit_hit;

  assign is_delim  = (byte_in == swsplit_pkg::CH_SPACE) || (byte_in == swsplit_pkg::CH_TAB) ||
                     (byte_in == swsplit_pkg::CH_NEWLINE);
  assign quoted    = st.in_dquote || st.in_squote;
  assign words_inc = st.words_done + 1'b1;
  assign limit_hit = (words_inc >= max_words);

  always_comb begin
    st_next    = st;
    res0_valid = 1'b0;
    res1_valid = 1'b0;
    res0       = '{kind: swsplit_pkg::KIND_BYTE, byte_out: byte_in,
                   word_count: st.words_done, status: swsplit_pkg::ST_OK, last: 1'b1};
    res1       = '{kind: swsplit_pkg::KIND_LINE_DONE, byte_out: '0,
                   word_count: st.words_done, status: swsplit_pkg::ST_OK, last: 1'b1};

    if (line_end) begin
      // terminator: optional word end, then line done; state clears
      res0_valid = 1'b1;
      res0.kind     = swsplit_pkg::KIND_LINE_DONE;
      res0.byte_out = '0;
      if (st.overflowed) begin
        res0.status = swsplit_pkg::ST_TOO_MANY;
      end else if (quoted) begin
        res0.status = swsplit_pkg::ST_UNMATCHED;
      end else if (st.in_word) begin
        res0.kind       = swsplit_pkg::KIND_WORD_END;
        res0.word_count = words_inc;
        res0.last       = 1'b0;
        res1_valid      = 1'b1;
        res1.word_count = words_inc;
        res1.status     = limit_hit ? swsplit_pkg::ST_TOO_MANY : swsplit_pkg::ST_OK;
      end
      st_next = '0;
    end else if (!st.overflowed && (st.in_word || !is_delim)) begin
      st_next.in_word = 1'b1;
      if (st.escape_pending) begin
        st_next.escape_pending = 1'b0;
        res0_valid = 1'b1;
      end else if (byte_in == swsplit_pkg::CH_BACKSLASH) begin
        st_next.escape_pending = 1'b1;
      end else if (byte_in == swsplit_pkg::CH_DQUOTE && !st.in_squote) begin
        st_next.in_dquote = !st.in_dquote;
      end else if (byte_in == swsplit_pkg::CH_SQUOTE && !st.in_dquote) begin
        st_next.in_squote = !st.in_squote;
      end else if (is_delim && !quoted) begin
        st_next.in_word    = 1'b0;
        st_next.words_done = words_inc;
        st_next.overflowed = limit_hit;
        res0_valid      = 1'b1;
        res0.kind       = swsplit_pkg::KIND_WORD_END;
        res0.byte_out   = '0;
        res0.word_count = words_inc;
      end else begin
        res0_valid = 1'b1;
      end
    end
  end

endmodule

>>> design/shell_word_splitter_core.sv
// channel   | dir | tdata                                   | tuser     | tlast
// s_axis    | in  | [7:0] byte_in                           | -         | line_end
// m_axis    | out | [7:0] byte_out [17:8] word_count        | [1:0] kind| last
//           |     | [19:18] status, [23:20] zero            |           |
// cfg       | in  | cfg_wr_data[9:0] max_words on cfg_wr_en |           |
//
// one input beat per cycle is taken while s_axis_tready is high; the tokenizer
// rule is evaluated in the same cycle from the line state and its results go
// to a four-entry queue; a character beat makes zero or one result, a
// terminator one or two, so the output side, at one result per cycle while
// m_axis_tready is high, sets the rate at which input beats are taken
// s_axis_tready is high while the queue has room for two results
// rst (synchronous) clears the line state, empties the queue and sets
// max_words to 64
module shell_word_splitter_core (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,   // line_end
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [17:8] word_count, [19:18] status
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast,   // last result of the input beat
  // configuration
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data     // max_words
);

  logic [swsplit_pkg::COUNT_W-1:0] max_words;

  swsplit_pkg::split_state_t st;
  swsplit_pkg::split_state_t st_next;

  logic                 res0_valid;
  logic                 res1_valid;
  swsplit_pkg::result_t res0;
  swsplit_pkg::result_t res1;

  // result queue
  swsplit_pkg::result_t            queue [swsplit_pkg::QUEUE_DEPTH];
  logic [swsplit_pkg::QPTR_W-1:0]  wr_ptr;
  logic [swsplit_pkg::QPTR_W-1:0]  rd_ptr;
  logic [swsplit_pkg::QCNT_W-1:0]  fill;
  logic [swsplit_pkg::QCNT_W-1:0]  fill_next;
  logic [swsplit_pkg::QPTR_W-1:0]  wr_ptr_next;

  logic in_fire;
  logic out_fire;
  logic push0;
  logic push1;
  swsplit_pkg::result_t head;

  swsplit_step u_step (
    .st         (st),
    .byte_in    (s_axis_tdata),
    .line_end   (s_axis_tlast),
    .max_words  (max_words),
    .st_next    (st_next),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  // room for the worst case of two results
  assign s_axis_tready = (fill <= swsplit_pkg::QCNT_W'(swsplit_pkg::QUEUE_DEPTH - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign push0         = in_fire && res0_valid;
  assign push1         = in_fire && res1_valid;

  always_comb begin
    fill_next   = fill + swsplit_pkg::QCNT_W'(push0) + swsplit_pkg::QCNT_W'(push1)
                  - swsplit_pkg::QCNT_W'(out_fire);
    wr_ptr_next = wr_ptr + swsplit_pkg::QPTR_W'(push0) + swsplit_pkg::QPTR_W'(push1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_words <= swsplit_pkg::MAX_WORDS_RESET;
      st        <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      fill      <= '0;
    end else begin
      if (cfg_wr_en) begin
        max_words <= cfg_wr_data;
      end
      if (in_fire) begin
        st <= st_next;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (push0) begin
      queue[wr_ptr] <= res0;
    end
    if (push1) begin
      queue[wr_ptr + 1'b1] <= res1;
    end
  end

  assign head          = queue[rd_ptr];
  assign m_axis_tvalid = (fill != '0);
  assign m_axis_tdata  = {4'b0000, head.status, head.word_count, head.byte_out};
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

endmodule

>>> tb/sv/tb.sv
module tb;
  import swsplit_pkg::*;

  // receiver stall patterns, each picked at random and held for a random stretch
  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_QUARTER,
    RX_CADENCE
  } rx_mode_t;

  // longest legal quiet stretch is the long output hold-off below
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STUCK_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 8;

  // mirrors the line state and turns every accepted beat into the tokens
  // the splitter should emit, oldest first
  class token_scoreboard;
    logic [COUNT_W-1:0] word_limit = MAX_WORDS_RESET;
    bit                 in_word, in_dq, in_sq, escaped, overflowed;
    logic [COUNT_W-1:0] words_done = '0;
    result_t            due_tokens[$];
    int n_errors, n_checked, n_lines, n_ok, n_unmatched, n_too_many, n_word_ends;

    function void set_limit(logic [COUNT_W-1:0] v);
      word_limit = v;
    endfunction

    function int pending();
      return due_tokens.size();
    endfunction

    function void queue_token(kind_t k, logic [BYTE_W-1:0] ch, status_t st, bit last);
      result_t r;
      r.kind       = k;
      r.byte_out   = ch;
      r.word_count = words_done;
      r.status     = st;
      r.last       = last;
      due_tokens.push_back(r);
    endfunction

    function bit is_blank(logic [BYTE_W-1:0] ch);
      return ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE;
    endfunction

    // a completed word may hit the limit, after which the line is swallowed
    function void close_word(bit last);
      in_word    = 1'b0;
      words_done = words_done + 1'b1;
      if (words_done >= word_limit) overflowed = 1'b1;
      n_word_ends++;
      queue_token(KIND_WORD_END, '0, ST_OK, last);
    endfunction

    function void absorb_beat(logic [BYTE_W-1:0] ch, bit line_end);
      status_t st;
      if (line_end) begin
        if (overflowed) begin
          st = ST_TOO_MANY;
        end else if (in_dq || in_sq) begin
          st = ST_UNMATCHED;
        end else begin
          if (in_word) close_word(1'b0);
          st = overflowed ? ST_TOO_MANY : ST_OK;
        end
        queue_token(KIND_LINE_DONE, '0, st, 1'b1);
        n_lines++;
        case (st)
          ST_OK:        n_ok++;
          ST_UNMATCHED: n_unmatched++;
          default:      n_too_many++;
        endcase
        {in_word, in_dq, in_sq, escaped, overflowed} = '0;
        words_done = '0;
        return;
      end
      if (overflowed) return;
      if (!in_word) begin
        if (is_blank(ch)) return;
        in_word = 1'b1;
      end
      if (escaped) begin
        escaped = 1'b0;
        queue_token(KIND_BYTE, ch, ST_OK, 1'b1);
      end else if (ch == CH_BACKSLASH) begin
        escaped = 1'b1;
      end else if (ch == CH_DQUOTE && !in_sq) begin
        in_dq = !in_dq;
      end else if (ch == CH_SQUOTE && !in_dq) begin
        in_sq = !in_sq;
      end else if (is_blank(ch) && !in_dq && !in_sq) begin
        close_word(1'b1);
      end else begin
        queue_token(KIND_BYTE, ch, ST_OK, 1'b1);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        n_errors++;
        $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      end
    endfunction

    function void match_result(result_t seen);
      result_t want;
      if (due_tokens.size() == 0) begin
        n_errors++;
        $error("unexpected result beat: kind %0d byte %02h", seen.kind, seen.byte_out);
        return;
      end
      want = due_tokens.pop_front();
      n_checked++;
      compare_field("kind", 32'(want.kind), 32'(seen.kind));
      compare_field("byte_out", 32'(want.byte_out), 32'(seen.byte_out));
      compare_field("word_count", 32'(want.word_count), 32'(seen.word_count));
      compare_field("status", 32'(want.status), 32'(seen.status));
      compare_field("last", 32'(want.last), 32'(seen.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic [9:0]  cfg_wr_data = '0;

  token_scoreboard sb = new;
  result_t         seen_beat;

  // sender burst bookkeeping and run statistics
  int       burst_left;
  bit       gaps_on = 1'b1;
  int       beats_sent;
  int       n_settings;
  // receiver side: stall pattern and the long hold-off request
  int       hold_cycles;
  int       mode_left;
  int       rx_tick;
  rx_mode_t rx_mode = RX_ALWAYS;
  int       stuck_cycles;

  always #5 clk = ~clk;

  shell_word_splitter_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // input beats are noted before result beats are matched, so a result that
  // showed up in the same cycle as its cause would still find its token
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.absorb_beat(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        seen_beat.kind       = kind_t'(m_axis_tuser);
        seen_beat.byte_out   = m_axis_tdata[7:0];
        seen_beat.word_count = m_axis_tdata[17:8];
        seen_beat.status     = status_t'(m_axis_tdata[19:18]);
        seen_beat.last       = m_axis_tlast;
        sb.match_result(seen_beat);
      end
    end
  end

  // receiver: a pattern picked at random and held for a random stretch, overridden by
  // a long hold-off when the stimulus asks for one
  always @(negedge clk) begin
    rx_tick++;
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end
    mode_left--;
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready <= 1'b1;
        RX_HALF:    m_axis_tready <= 1'($urandom_range(0, 1));
        RX_QUARTER: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:    m_axis_tready <= (rx_tick % 3 != 0);
      endcase
    end
  end

  // watchdog: too long without any beat moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", STUCK_LIMIT);
      $display("shell_word_splitter_core test failed");
      $finish;
    end
  end

  // one input beat; bursts of random length with idle gaps in between while gaps_on is set
  task automatic send_item(input logic [7:0] ch, input bit line_end);
    if (gaps_on && burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk) s_axis_tvalid <= 1'b0;
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= line_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    beats_sent++;
  endtask

  // characters of a string, then optionally a terminator with a junk byte
  task automatic send_text(input string s, input bit close_line);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    if (close_line) send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // stop offering, let every token arrive, then let the pipe settle
  task automatic drain_results();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [9:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
    sb.set_limit(v);
    n_settings++;
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NEWLINE;
    endcase
  endfunction

  // content of a quoted run: letters, blanks and the other quote mark
  function automatic logic [7:0] quoted_char(logic [7:0] q);
    case ($urandom_range(0, 4))
      0:       return pick_blank();
      1:       return (q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE;
      default: return pick_letter();
    endcase
  endfunction

  // one piece of a word: plain letter, escaped byte, quoted run or raw byte
  task automatic send_piece();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_item(pick_letter(), 1'b0);
      4: begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b0);
      end
      5, 6, 7: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send_item(q, 1'b0);
        repeat ($urandom_range(0, 4)) send_item(quoted_char(q), 1'b0);
        send_item(q, 1'b0);
      end
      default: send_item(8'($urandom_range(0, 255)), 1'b0);
    endcase
  endtask

  // mostly well-formed lines with random words; some pure noise lines and
  // some lines broken by an open quote or a trailing backslash
  task automatic send_line();
    int n_words;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 16)) send_item(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      n_words = $urandom_range(0, 6);
      repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
      repeat (n_words) begin
        repeat ($urandom_range(1, 4)) send_piece();
        repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 2))
          0:       send_item(CH_DQUOTE, 1'b0);
          1:       send_item(CH_SQUOTE, 1'b0);
          default: send_item(CH_BACKSLASH, 1'b0);
        endcase
      end
    end
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic run_lines(input int quota);
    int start;
    start = beats_sent;
    while (beats_sent - start < quota) send_line();
    drain_results();
  endtask

  initial begin
    logic [9:0] lim;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // reset limit: blanks around words, quoted blank, empty quoted word
    send_text(" a\t\"b c\"\n\"\"", 1'b1);
    // lone backslash at line end still makes an empty word
    send_text("\\", 1'b1);
    // escape inside single quotes, quote left open
    send_text("'\\'", 1'b1);
    // zero byte and all-ones byte are ordinary characters
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    // empty line
    send_item(8'hff, 1'b1);
    drain_results();

    // limit of one: overflow mid-line swallows the rest, and at the terminator
    write_limit(10'd1);
    send_text("a b", 1'b1);
    send_text("ab", 1'b1);
    drain_results();

    write_limit(10'd1023);
    run_lines(120);

    for (int p = 0; p < 6; p++) begin
      case (p)
        2:       lim = 10'd1;
        4:       lim = 10'($urandom_range(11, 1022));
        default: lim = 10'($urandom_range(2, 10));
      endcase
      write_limit(lim);
      gaps_on = (p % 2 == 0);
      // output held off for a long stretch while input keeps coming
      if (p == 3) hold_cycles = HOLD_OFF_CYCLES;
      run_lines(125);
    end

    if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
    $display("run covered %0d input beats and %0d result beats over %0d limit settings",
             beats_sent, sb.n_checked, n_settings);
    $display("lines: %0d ok, %0d unmatched quote, %0d too many words; %0d word ends",
             sb.n_ok, sb.n_unmatched, sb.n_too_many, sb.n_word_ends);
    if (sb.n_errors == 0 && sb.pending() == 0)
      $display("shell_word_splitter_core test passed");
    else
      $display("shell_word_splitter_core test failed");
    $finish;
  end

endmodule

>>> sim.f
design/swsplit_pkg.sv
design/swsplit_step.sv
design/shell_word_splitter_core.sv
tb/sv/tb.sv
